// File: rtl/core/eah_pkg.sv
// shared constants, types and angle boundary table for the energy/angle histogram
`timescale 1ns / 1ps

package eah_pkg;

  // histogram geometry
  localparam int BINS    = 256;
  localparam int BinW    = 8;
  localparam int StepW   = 3;
  localparam int CntW    = 32;

  // field and register widths
  localparam int CfgW    = 24;
  localparam int CfgIdxW = 2;
  localparam int CmdW    = 2;
  localparam int DzW     = 16;

  // shared compare/subtract unit and angle compare format
  localparam int AluW    = 33;
  localparam int BoundW  = 32;
  localparam int DzShift = 13;
  localparam int QFrac   = 28;

  // command codes
  localparam logic [CmdW-1:0] CMD_HIT       = 2'd0;
  localparam logic [CmdW-1:0] CMD_RD_ENERGY = 2'd1;
  localparam logic [CmdW-1:0] CMD_RD_ANGLE  = 2'd2;
  localparam logic [CmdW-1:0] CMD_RD_HIGH   = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ENERGY_LOW  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ENERGY_HIGH = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD   = 2'd2;

  // register reset values in kev
  localparam logic [CfgW-1:0] ENERGY_LOW_RST  = 24'd0;
  localparam logic [CfgW-1:0] ENERGY_HIGH_RST = 24'd25000;
  localparam logic [CfgW-1:0] THRESHOLD_RST   = 24'd19500;

  localparam logic [CntW-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [CmdW-1:0]       cmd;
    logic                  is_gamma;
    logic [CfgW-1:0]       energy_kev;
    logic signed [DzW-1:0] dir_z;
    logic [BinW-1:0]       bin_addr;
  } eah_req_t;

  typedef struct packed {
    logic [CntW-1:0] read_value;
    logic            energy_counted;
    logic            angle_counted;
  } eah_rsp_t;

  // histogram bank write port
  typedef struct packed {
    logic            en;
    logic [BinW-1:0] addr;
    logic [CntW-1:0] data;
  } bank_wr_t;

  typedef logic [63:0]        u64_t;
  typedef logic signed [63:0] s64_t;
  typedef logic signed [BoundW-1:0] bound_t;
  typedef bound_t bound_tab_t [BINS];

  // taylor series for cos in q28, evaluated at elaboration only
  localparam int CosTerms = 20;
  localparam u64_t CosDen = u64_t'(100 * BINS);
  localparam u64_t PiX100 = 64'd314;
  localparam u64_t TaylorDiv [1:CosTerms] = '{
    64'd2,   64'd12,  64'd30,  64'd56,  64'd90,  64'd132, 64'd182, 64'd240,
    64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756, 64'd870, 64'd992,
    64'd1122, 64'd1260, 64'd1406, 64'd1560
  };

  function automatic s64_t cos_q28(input u64_t x);
    u64_t x2;
    u64_t term;
    s64_t sum;
    x2   = (x * x) >> QFrac;
    term = u64_t'(1) << QFrac;
    sum  = s64_t'(term);
    for (int i = 1; i <= CosTerms; i++) begin
      term = ((term * x2) >> QFrac) / TaylorDiv[i];
      if ((i & 1) != 0) begin
        sum = sum - s64_t'(term);
      end else begin
        sum = sum + s64_t'(term);
      end
    end
    return sum;
  endfunction

  // boundary angle k in q28 radians, k * 3.14 / BINS
  function automatic u64_t bound_theta(input int k);
    return (u64_t'(k) * PiX100 * (u64_t'(1) << QFrac)) / CosDen;
  endfunction

  function automatic bound_tab_t make_bounds();
    bound_tab_t t;
    for (int k = 0; k < BINS; k++) begin
      t[k] = BoundW'(cos_q28(bound_theta(k)));
    end
    return t;
  endfunction

  // boundary cosines for k = 0 .. BINS-1, and the last one at 3.14
  localparam bound_tab_t BOUND_TAB  = make_bounds();
  localparam bound_t     BOUND_LAST = BoundW'(cos_q28(bound_theta(BINS)));

endpackage

// File: rtl/core/eah_in_if.sv
// request channel interface for the energy/angle histogram
`timescale 1ns / 1ps

interface eah_in_if;
  logic             valid;
  logic             ready;
  eah_pkg::eah_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/eah_out_if.sv
// result channel interface for the energy/angle histogram
`timescale 1ns / 1ps

interface eah_out_if;
  logic             valid;
  logic             ready;
  eah_pkg::eah_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/energy_angle_histogram.sv
// top level of the gamma energy and angle histogram
`timescale 1ns / 1ps

// Gamma energy/angle histogram. Each request is a hit or a read. A gamma hit
// bumps the high-energy count when its energy is at or above the threshold,
// bins floor((E-low)*256/(high-low)) into the energy histogram and bins
// acos(dir_z) in steps of 3.14/256 into the angle histogram; bins out of
// range, and all energy bins when high <= low, are not counted. Counters
// saturate at 2^32-1. Reads return one bin or the high-energy count; every
// request gives exactly one result. After reset the block clears both
// histograms, one bin of each per cycle, with in_if.ready low; configuration
// writes are taken during that time. Steps per request: a gamma hit runs 8
// restoring division steps for the energy bin, 8 binary search steps over
// the boundary cosine table plus one check of the last boundary, all on one
// shared compare/subtract unit, then a read-modify-write of each counted
// bin; a non-gamma hit and a high-count read go straight to the result, a
// bin read first reads the bin. The result sits in an output register, so a
// new request is taken while an earlier result still waits to be taken.
module energy_angle_histogram (
  input  logic                          clk,
  input  logic                          rst_n,
  eah_in_if.sink                        in_if,
  eah_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [eah_pkg::CfgIdxW-1:0]   cfg_addr,
  input  logic [eah_pkg::CfgW-1:0]      cfg_wdata
);

  // sequencer states
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DIV   = 4'd2;
  localparam logic [3:0] ST_SRCH  = 4'd3;
  localparam logic [3:0] ST_LAST  = 4'd4;
  localparam logic [3:0] ST_ERD   = 4'd5;
  localparam logic [3:0] ST_EWR   = 4'd6;
  localparam logic [3:0] ST_ARD   = 4'd7;
  localparam logic [3:0] ST_AWR   = 4'd8;
  localparam logic [3:0] ST_RRD   = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  logic [3:0]                   state_r, state_nxt;
  logic [eah_pkg::BinW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [eah_pkg::StepW-1:0]    step_r, step_nxt;
  eah_pkg::eah_req_t            req_r, req_nxt;
  logic [eah_pkg::CfgW-1:0]     rem_r, rem_nxt;
  logic [eah_pkg::CfgW-1:0]     den_r, den_nxt;
  logic [eah_pkg::BinW-1:0]     ebin_r, ebin_nxt;
  logic [eah_pkg::BinW-1:0]     abin_r, abin_nxt;
  logic                         e_ok_r, e_ok_nxt;
  logic                         a_ok_r, a_ok_nxt;
  logic [eah_pkg::CntW-1:0]     rv_r, rv_nxt;
  logic                         ec_r, ec_nxt;
  logic                         ac_r, ac_nxt;
  logic [eah_pkg::CntW-1:0]     high_cnt_r, high_cnt_nxt;
  logic [eah_pkg::CfgW-1:0]     low_r, low_nxt;
  logic [eah_pkg::CfgW-1:0]     high_r, high_nxt;
  logic [eah_pkg::CfgW-1:0]     thr_r, thr_nxt;
  logic                         out_valid_r, out_valid_nxt;
  eah_pkg::eah_rsp_t            out_data_r, out_data_nxt;

  logic                         in_fire;
  logic                         out_take;
  logic                         done_load;

  // energy range checks on the incoming request
  logic [eah_pkg::CfgW-1:0]     e_minus_low;
  logic [eah_pkg::CfgW-1:0]     den_in;
  logic                         e_ok_in;
  logic                         hi_hit;

  // shared unit operands
  logic signed [eah_pkg::AluW-1:0] alu_a;
  logic signed [eah_pkg::AluW-1:0] alu_b;
  logic                            alu_ge;
  logic [eah_pkg::AluW-1:0]        alu_diff;
  logic [eah_pkg::BinW-1:0]        cand;
  eah_pkg::bound_t                 cand_bound;
  logic signed [eah_pkg::AluW-1:0] dzq;

  // histogram banks
  eah_pkg::bank_wr_t            e_wr;
  eah_pkg::bank_wr_t            a_wr;
  logic [eah_pkg::BinW-1:0]     e_raddr;
  logic [eah_pkg::BinW-1:0]     a_raddr;
  logic [eah_pkg::CntW-1:0]     e_rdata;
  logic [eah_pkg::CntW-1:0]     a_rdata;
  logic [eah_pkg::CntW-1:0]     e_inc;
  logic [eah_pkg::CntW-1:0]     a_inc;

  // handshakes: one request in flight, result register parts the two sides
  assign in_if.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;
  assign out_take     = out_valid_r && out_if.ready;
  assign done_load    = (state_r == ST_DONE) && (!out_valid_r || out_if.ready);

  // the bin is in range exactly when low <= E and E-low < high-low, so the quotient
  // then fits in 8 bits and the division needs only 8 steps
  assign e_minus_low = in_if.data.energy_kev - low_r;
  assign den_in      = high_r - low_r;
  assign e_ok_in     = (high_r > low_r) && (in_if.data.energy_kev >= low_r) &&
                       (e_minus_low < den_in);
  assign hi_hit      = (in_if.data.energy_kev >= thr_r);

  // dir_z scaled from q15 to q28 for the boundary compare
  assign dzq = {{(eah_pkg::AluW - eah_pkg::DzW - eah_pkg::DzShift){req_r.dir_z[eah_pkg::DzW-1]}},
                req_r.dir_z, {eah_pkg::DzShift{1'b0}}};

  // binary search candidate: current index with the bit under test set
  always_comb begin
    cand         = abin_r;
    cand[step_r] = 1'b1;
  end

  assign cand_bound = eah_pkg::BOUND_TAB[cand];

  // operand select for the shared unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_r)
      ST_DIV: begin
        // restoring division step: compare 2*rem against the range width
        alu_a = {{(eah_pkg::AluW - eah_pkg::CfgW - 1){1'b0}}, rem_r, 1'b0};
        alu_b = {{(eah_pkg::AluW - eah_pkg::CfgW){1'b0}}, den_r};
      end
      ST_SRCH: begin
        // boundary cosines fall with k, so t[cand] >= dz moves the index up
        alu_a = {{(eah_pkg::AluW - eah_pkg::BoundW){cand_bound[eah_pkg::BoundW-1]}},
                 cand_bound};
        alu_b = dzq;
      end
      ST_LAST: begin
        alu_a = {{(eah_pkg::AluW - eah_pkg::BoundW){eah_pkg::BOUND_LAST[eah_pkg::BoundW-1]}},
                 eah_pkg::BOUND_LAST};
        alu_b = dzq;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  eah_alu u_alu (
    .op_a   (alu_a),
    .op_b   (alu_b),
    .a_ge_b (alu_ge),
    .diff   (alu_diff)
  );

  // saturating increments of the bin read back
  assign e_inc = (e_rdata == eah_pkg::CNT_MAX) ? e_rdata : e_rdata + eah_pkg::CntW'(1);
  assign a_inc = (a_rdata == eah_pkg::CNT_MAX) ? a_rdata : a_rdata + eah_pkg::CntW'(1);

  // bank ports: clear sweep after reset, else read-modify-write of one bin
  always_comb begin
    e_wr.en   = (state_r == ST_CLEAR) || (state_r == ST_EWR);
    e_wr.addr = (state_r == ST_CLEAR) ? clr_idx_r : ebin_r;
    e_wr.data = (state_r == ST_CLEAR) ? '0 : e_inc;
    a_wr.en   = (state_r == ST_CLEAR) || (state_r == ST_AWR);
    a_wr.addr = (state_r == ST_CLEAR) ? clr_idx_r : abin_r;
    a_wr.data = (state_r == ST_CLEAR) ? '0 : a_inc;
    e_raddr   = (state_r == ST_IDLE) ? in_if.data.bin_addr : ebin_r;
    a_raddr   = (state_r == ST_IDLE) ? in_if.data.bin_addr : abin_r;
  end

  eah_hist_bank u_energy_bank (
    .clk   (clk),
    .wr    (e_wr),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  eah_hist_bank u_angle_bank (
    .clk   (clk),
    .wr    (a_wr),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    step_nxt      = step_r;
    req_nxt       = req_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    ebin_nxt      = ebin_r;
    abin_nxt      = abin_r;
    e_ok_nxt      = e_ok_r;
    a_ok_nxt      = a_ok_r;
    rv_nxt        = rv_r;
    ec_nxt        = ec_r;
    ac_nxt        = ac_r;
    high_cnt_nxt  = high_cnt_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    thr_nxt       = thr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == eah_pkg::BinW'(eah_pkg::BINS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt  = in_if.data;
          rv_nxt   = '0;
          ec_nxt   = 1'b0;
          ac_nxt   = 1'b0;
          rem_nxt  = e_minus_low;
          den_nxt  = den_in;
          e_ok_nxt = e_ok_in;
          a_ok_nxt = 1'b0;
          ebin_nxt = '0;
          abin_nxt = '0;
          step_nxt = '1;
          case (in_if.data.cmd)
            eah_pkg::CMD_HIT: begin
              if (in_if.data.is_gamma) begin
                state_nxt = ST_DIV;
                if (hi_hit && (high_cnt_r != eah_pkg::CNT_MAX)) begin
                  high_cnt_nxt = high_cnt_r + eah_pkg::CntW'(1);
                end
              end else begin
                state_nxt = ST_DONE;
              end
            end
            eah_pkg::CMD_RD_ENERGY, eah_pkg::CMD_RD_ANGLE: begin
              state_nxt = ST_RRD;
            end
            eah_pkg::CMD_RD_HIGH: begin
              rv_nxt    = high_cnt_r;
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_nxt  = alu_ge ? alu_diff[eah_pkg::CfgW-1:0] : {rem_r[eah_pkg::CfgW-2:0], 1'b0};
        ebin_nxt = {ebin_r[eah_pkg::BinW-2:0], alu_ge};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          step_nxt  = '1;
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (alu_ge) begin
          abin_nxt = cand;
        end
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        // at or below the last boundary the angle is past 3.14: dropped
        a_ok_nxt = !alu_ge;
        if (e_ok_r) begin
          state_nxt = ST_ERD;
        end else if (!alu_ge) begin
          state_nxt = ST_ARD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_ERD: begin
        state_nxt = ST_EWR;
      end
      ST_EWR: begin
        ec_nxt    = 1'b1;
        state_nxt = a_ok_r ? ST_ARD : ST_DONE;
      end
      ST_ARD: begin
        state_nxt = ST_AWR;
      end
      ST_AWR: begin
        ac_nxt    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_RRD: begin
        rv_nxt    = (req_r.cmd == eah_pkg::CMD_RD_ENERGY) ? e_rdata : a_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (done_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // result register
    if (done_load) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.read_value     = rv_r;
      out_data_nxt.energy_counted = ec_r;
      out_data_nxt.angle_counted  = ac_r;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end

    // configuration writes, out-of-range index ignored
    if (cfg_we) begin
      case (cfg_addr)
        eah_pkg::REG_ENERGY_LOW:  low_nxt  = cfg_wdata;
        eah_pkg::REG_ENERGY_HIGH: high_nxt = cfg_wdata;
        eah_pkg::REG_THRESHOLD:   thr_nxt  = cfg_wdata;
        default: begin
          low_nxt = low_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      high_cnt_r  <= '0;
      low_r       <= eah_pkg::ENERGY_LOW_RST;
      high_r      <= eah_pkg::ENERGY_HIGH_RST;
      thr_r       <= eah_pkg::THRESHOLD_RST;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      high_cnt_r  <= high_cnt_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      thr_r       <= thr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    req_r      <= req_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    ebin_r     <= ebin_nxt;
    abin_r     <= abin_nxt;
    e_ok_r     <= e_ok_nxt;
    a_ok_r     <= a_ok_nxt;
    rv_r       <= rv_nxt;
    ec_r       <= ec_nxt;
    ac_r       <= ac_nxt;
    out_data_r <= out_data_nxt;
  end

  // high-energy count only ever grows
  a_high_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> high_cnt_r >= $past(high_cnt_r))
    else $error("high-energy count decreased");

  // a hit result never carries a read value
  a_hit_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.data.energy_counted || out_if.data.angle_counted)
    |-> out_if.data.read_value == '0)
    else $error("hit result with nonzero read value");

  // division remainder stays below the range width for in-range energies
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && e_ok_r |-> rem_r < den_r)
    else $error("division remainder out of range");

endmodule

// File: rtl/core/eah_alu.sv
// shared signed compare/subtract unit used by the division and the table search
`timescale 1ns / 1ps

module eah_alu (
  input  logic signed [eah_pkg::AluW-1:0] op_a,
  input  logic signed [eah_pkg::AluW-1:0] op_b,
  output logic                            a_ge_b,
  output logic [eah_pkg::AluW-1:0]        diff
);

  logic [eah_pkg::AluW:0] wide;

  // one extra bit so the sign of the difference is exact
  assign wide   = {op_a[eah_pkg::AluW-1], op_a} - {op_b[eah_pkg::AluW-1], op_b};
  assign a_ge_b = ~wide[eah_pkg::AluW];
  assign diff   = wide[eah_pkg::AluW-1:0];

endmodule

// File: rtl/core/eah_hist_bank.sv
// one histogram bank: single write port, registered read port
`timescale 1ns / 1ps

module eah_hist_bank (
  input  logic                        clk,
  input  eah_pkg::bank_wr_t           wr,
  input  logic [eah_pkg::BinW-1:0]    raddr,
  output logic [eah_pkg::CntW-1:0]    rdata
);

  logic [eah_pkg::CntW-1:0] mem_r [eah_pkg::BINS];
  logic [eah_pkg::CntW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
